FILE: rtl/eip_pkg.sv
package eip_pkg;

    localparam int MAX_FRAME = 2048;
    localparam int IDX_W     = $clog2(MAX_FRAME + 1);

    localparam int ETH_HDR = 14;
    localparam int IP_HDR  = 20;
    localparam int UDP_HDR = 8;

    localparam logic [15:0] KIND_IP   = 16'h0800;
    localparam logic [15:0] KIND_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam logic [15:0] PORT_BOOTPS = 16'd67;
    localparam logic [15:0] PORT_BOOTPC = 16'd68;
    localparam logic [15:0] PORT_DNSS   = 16'd53;
    localparam logic [15:0] PORT_DNSC   = 16'd32769;

    localparam logic [15:0] CSUM_ONES = 16'hffff;

    localparam logic [3:0] V_ARP        = 4'd0;
    localparam logic [3:0] V_DHCP       = 4'd1;
    localparam logic [3:0] V_DNS        = 4'd2;
    localparam logic [3:0] V_SHORT_ETH  = 4'd3;
    localparam logic [3:0] V_BAD_TYPE   = 4'd4;
    localparam logic [3:0] V_SHORT_IP   = 4'd5;
    localparam logic [3:0] V_BAD_CSUM   = 4'd6;
    localparam logic [3:0] V_NOT_UDP    = 4'd7;
    localparam logic [3:0] V_SHORT_UDP  = 4'd8;
    localparam logic [3:0] V_PORT_MISS  = 4'd9;

    typedef struct packed {
        logic [IDX_W-1:0] frame_len;
        logic [15:0]      ether_kind;
        logic [19:0]      sum_accum;
        logic [15:0]      stored_csum;
        logic [7:0]       proto_byte;
        logic [15:0]      total_length;
        logic [15:0]      source_port;
        logic [15:0]      dst_port;
    } hdr_snap_t;

endpackage

FILE: rtl/eip_in_reg.sv
module eip_in_reg
    import eip_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       in_valid,
    output logic [7:0] in_byte,
    output logic       in_last,
    input  logic       in_ready
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign s_tready = !valid_reg || in_ready;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

endmodule

FILE: rtl/eip_hdr_track.sv
module eip_hdr_track
    import eip_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic [7:0] in_byte,
    input  logic      in_last,
    output logic      in_ready,
    output logic      snap_valid,
    output hdr_snap_t snap,
    input  logic      snap_ready
);

    localparam logic [IDX_W-1:0] MAX_IDX  = IDX_W'(MAX_FRAME);
    localparam logic [IDX_W-1:0] POS_TYPE = IDX_W'(12);
    localparam logic [IDX_W-1:0] POS_IP   = IDX_W'(ETH_HDR);
    localparam logic [IDX_W-1:0] POS_UDP  = IDX_W'(ETH_HDR + IP_HDR);

    logic [IDX_W-1:0] idx_reg, idx_next, idx_upd;
    logic [15:0]      kind_reg, kind_next, kind_upd;
    logic [19:0]      sum_reg, sum_next, sum_upd;
    logic [15:0]      csum_reg, csum_next, csum_upd;
    logic [7:0]       proto_reg, proto_next, proto_upd;
    logic [15:0]      tlen_reg, tlen_next, tlen_upd;
    logic [15:0]      sport_reg, sport_next, sport_upd;
    logic [15:0]      dport_reg, dport_next, dport_upd;
    logic [7:0]       high_reg, high_next, high_upd;
    logic             snap_valid_reg, snap_valid_next;
    hdr_snap_t        snap_reg, snap_next;

    logic             go;
    logic             snap_free;
    logic [4:0]       ofs;
    logic [15:0]      word;

    assign snap_free  = !snap_valid_reg || snap_ready;
    assign go         = in_valid && (!in_last || snap_free);
    assign in_ready   = !in_valid || go;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;
    assign ofs        = 5'(idx_reg - POS_IP);
    assign word       = {high_reg, in_byte};

    always_comb begin
        idx_upd   = idx_reg;
        kind_upd  = kind_reg;
        sum_upd   = sum_reg;
        csum_upd  = csum_reg;
        proto_upd = proto_reg;
        tlen_upd  = tlen_reg;
        sport_upd = sport_reg;
        dport_upd = dport_reg;
        high_upd  = high_reg;
        if (idx_reg < MAX_IDX) begin
            idx_upd = idx_reg + 1'b1;
            if (idx_reg == POS_TYPE) begin
                kind_upd[15:8] = in_byte;
            end else if (idx_reg == POS_TYPE + 1'b1) begin
                kind_upd[7:0] = in_byte;
            end else if (idx_reg >= POS_IP && idx_reg < POS_UDP) begin
                if (!ofs[0]) begin
                    high_upd = in_byte;
                end else begin
                    high_upd = 8'd0;
                    if (ofs == 5'd11) begin
                        csum_upd = word;
                    end else begin
                        sum_upd = sum_reg + 20'(word);
                    end
                end
                case (ofs)
                    5'd2:    tlen_upd[15:8] = in_byte;
                    5'd3:    tlen_upd[7:0]  = in_byte;
                    5'd9:    proto_upd      = in_byte;
                    5'd10:   csum_upd       = {in_byte, 8'd0};
                    default: ;
                endcase
            end else if (idx_reg == POS_UDP) begin
                sport_upd[15:8] = in_byte;
            end else if (idx_reg == POS_UDP + IDX_W'(1)) begin
                sport_upd[7:0] = in_byte;
            end else if (idx_reg == POS_UDP + IDX_W'(2)) begin
                dport_upd[15:8] = in_byte;
            end else if (idx_reg == POS_UDP + IDX_W'(3)) begin
                dport_upd[7:0] = in_byte;
            end
        end
    end

    always_comb begin
        idx_next        = idx_reg;
        kind_next       = kind_reg;
        sum_next        = sum_reg;
        csum_next       = csum_reg;
        proto_next      = proto_reg;
        tlen_next       = tlen_reg;
        sport_next      = sport_reg;
        dport_next      = dport_reg;
        high_next       = high_reg;
        snap_next       = snap_reg;
        snap_valid_next = snap_valid_reg && !snap_ready;
        if (go) begin
            if (in_last) begin
                idx_next               = '0;
                kind_next              = '0;
                sum_next               = '0;
                csum_next              = '0;
                proto_next             = '0;
                tlen_next              = '0;
                sport_next             = '0;
                dport_next             = '0;
                high_next              = '0;
                snap_valid_next        = 1'b1;
                snap_next.frame_len    = idx_upd;
                snap_next.ether_kind   = kind_upd;
                snap_next.sum_accum    = sum_upd;
                snap_next.stored_csum  = csum_upd;
                snap_next.proto_byte   = proto_upd;
                snap_next.total_length = tlen_upd;
                snap_next.source_port  = sport_upd;
                snap_next.dst_port     = dport_upd;
            end else begin
                idx_next   = idx_upd;
                kind_next  = kind_upd;
                sum_next   = sum_upd;
                csum_next  = csum_upd;
                proto_next = proto_upd;
                tlen_next  = tlen_upd;
                sport_next = sport_upd;
                dport_next = dport_upd;
                high_next  = high_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            kind_reg       <= '0;
            sum_reg        <= '0;
            csum_reg       <= '0;
            proto_reg      <= '0;
            tlen_reg       <= '0;
            sport_reg      <= '0;
            dport_reg      <= '0;
            high_reg       <= '0;
            snap_valid_reg <= 1'b0;
        end else begin
            idx_reg        <= idx_next;
            kind_reg       <= kind_next;
            sum_reg        <= sum_next;
            csum_reg       <= csum_next;
            proto_reg      <= proto_next;
            tlen_reg       <= tlen_next;
            sport_reg      <= sport_next;
            dport_reg      <= dport_next;
            high_reg       <= high_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
    end

    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        go && in_last |=> idx_reg == '0 && snap_valid_reg)
        else $error("frame state not cleared after last beat");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= MAX_IDX)
        else $error("byte count past frame limit");

    a_snap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_valid_reg && !snap_ready |=> snap_valid_reg && $stable(snap_reg))
        else $error("pending header snapshot lost");

endmodule

FILE: rtl/eip_judge.sv
module eip_judge
    import eip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        snap_valid,
    input  hdr_snap_t   snap,
    output logic        snap_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [3:0]  verdict,
    output logic [15:0] payload_length
);

    localparam logic [IDX_W-1:0] LEN_ETH = IDX_W'(ETH_HDR);
    localparam logic [IDX_W-1:0] LEN_IP  = IDX_W'(ETH_HDR + IP_HDR);
    localparam logic [15:0]      LEN_UDP = 16'(IP_HDR + UDP_HDR);

    logic        valid_reg;
    logic [3:0]  verdict_reg, verdict_next;
    logic [15:0] plen_reg, plen_next;
    logic [16:0] fold;
    logic [15:0] csum_calc;

    assign snap_ready     = !valid_reg || m_tready;
    assign m_tvalid       = valid_reg;
    assign verdict        = verdict_reg;
    assign payload_length = plen_reg;

    assign fold      = 17'(snap.sum_accum[19:16]) + 17'(snap.sum_accum[15:0]);
    assign csum_calc = CSUM_ONES ^ (fold[15:0] + 16'(fold[16]));

    always_comb begin
        plen_next = 16'd0;
        if (snap.frame_len < LEN_ETH) begin
            verdict_next = V_SHORT_ETH;
        end else if (snap.ether_kind == KIND_ARP) begin
            verdict_next = V_ARP;
            plen_next    = 16'(snap.frame_len) - 16'(ETH_HDR);
        end else if (snap.ether_kind != KIND_IP) begin
            verdict_next = V_BAD_TYPE;
        end else if (snap.frame_len < LEN_IP) begin
            verdict_next = V_SHORT_IP;
        end else if (csum_calc != snap.stored_csum) begin
            verdict_next = V_BAD_CSUM;
        end else if (snap.proto_byte != PROTO_UDP) begin
            verdict_next = V_NOT_UDP;
        end else if (snap.total_length < LEN_UDP) begin
            verdict_next = V_SHORT_UDP;
        end else if (snap.dst_port == PORT_BOOTPC && snap.source_port == PORT_BOOTPS) begin
            verdict_next = V_DHCP;
            plen_next    = snap.total_length - LEN_UDP;
        end else if (snap.dst_port == PORT_DNSC && snap.source_port == PORT_DNSS) begin
            verdict_next = V_DNS;
            plen_next    = snap.total_length - LEN_UDP;
        end else begin
            verdict_next = V_PORT_MISS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (snap_ready) begin
            valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) begin
            verdict_reg <= verdict_next;
            plen_reg    <= plen_next;
        end
    end

    a_plen_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && plen_reg != 16'd0 |->
            verdict_reg == V_ARP || verdict_reg == V_DHCP || verdict_reg == V_DNS)
        else $error("payload length on an error verdict");

endmodule

FILE: rtl/eth_ip_udp_rx_classifier.sv
// Channel   Beat contents                                  Handshake
// s_        tdata[7:0] frame_byte, tlast last_byte         s_tvalid/s_tready
// m_        tdata[3:0] verdict, [19:4] payload_length      m_tvalid/m_tready
//
// One byte per cycle while no stalled result holds back a last beat.
// Three register stages: input, header tracker, verdict; a stall can hold each of them.
// Synchronous active-low reset clears the frame state and all valid flags.
// A stalled result only blocks a last beat; other bytes keep flowing.
module eth_ip_udp_rx_classifier
    import eip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [3:0] verdict, [19:4] payload_length, [23:20] zero
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
    logic       in_ready;
    logic       snap_valid;
    logic       snap_ready;
    hdr_snap_t  snap;
    logic [3:0]  verdict;
    logic [15:0] payload_length;

    eip_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .in_ready (in_ready)
    );

    eip_hdr_track u_hdr_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .in_ready   (in_ready),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    eip_judge u_judge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .snap_valid     (snap_valid),
        .snap           (snap),
        .snap_ready     (snap_ready),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .verdict        (verdict),
        .payload_length (payload_length)
    );

    assign m_tdata = {4'd0, payload_length, verdict};

endmodule
